/* hdl/kwm_pkg.sv */
`default_nettype none

package kwm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PTR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_LISTS * LIST_DEPTH);
    localparam int STORE_SIZE = NUM_LISTS * LIST_DEPTH;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               command;
        logic [2:0]         list_index;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] merged_value;
        logic [2:0]         source_list;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN,
        ST_DRAIN,
        ST_TAKE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* hdl/k_way_sorted_merge_unit.sv */
`default_nettype none

// Keeps NUM_LISTS sorted lists, each a FIFO of LIST_DEPTH signed 32-bit
// elements in one shared single-port element memory. An append transaction
// passes through capture of the request, read of the list's head and count
// together with the memory write, and result. A take transaction scans the
// list heads through the one memory read port, one list per cycle, and
// compares them with a single comparator, then drains the last read and
// takes the best head before the result. The block accepts one
// transaction at a time; a finished result sits in an output register so that
// the next transaction can be accepted while the result is still stalled. A
// take returns the smallest head, with the lowest list index winning ties;
// status reports done, list full (append dropped) or all lists empty.
module k_way_sorted_merge_unit
    import kwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req_item,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp_item
);

    state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg  [NUM_LISTS];
    logic [CNT_W-1:0] count_reg [NUM_LISTS];

    logic              upd_en;
    logic [LIST_W-1:0] upd_idx;
    logic [PTR_W-1:0]  upd_head;
    logic [CNT_W-1:0]  upd_count;

    logic [LIST_W-1:0]  list_reg, list_next;
    logic               range_reg, range_next;
    logic signed [31:0] val_reg, val_next;

    logic [LIST_W-1:0]  scan_idx_reg, scan_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_live_reg, pend_live_next;
    logic [LIST_W-1:0]  pend_list_reg, pend_list_next;
    logic               found_reg, found_next;
    logic [LIST_W-1:0]  best_reg, best_next;
    logic signed [31:0] best_val_reg, best_val_next;

    rsp_item_t res_reg, res_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg, rsp_item_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic signed [31:0] mem [STORE_SIZE];
    logic signed [31:0] rdata_reg;

    logic [LIST_W-1:0]  sel_idx;
    logic [PTR_W-1:0]   sel_head;
    logic [CNT_W-1:0]   sel_count;
    logic [ADDR_W-1:0]  sel_base;
    logic [CNT_W:0]     tail_sum;
    logic [CNT_W:0]     tail_wrap;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= val_reg;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            scan_idx_reg   <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            scan_idx_reg   <= scan_idx_next;
            if (upd_en)
            begin
                head_reg[upd_idx]  <= upd_head;
                count_reg[upd_idx] <= upd_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg      <= list_next;
        range_reg     <= range_next;
        val_reg       <= val_next;
        pend_live_reg <= pend_live_next;
        pend_list_reg <= pend_list_next;
        best_reg      <= best_next;
        best_val_reg  <= best_val_next;
        res_reg       <= res_next;
        rsp_item_reg  <= rsp_item_next;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SCAN: sel_idx = scan_idx_reg;
            ST_TAKE: sel_idx = best_reg;
            default: sel_idx = list_reg;
        endcase
        sel_head  = head_reg[sel_idx];
        sel_count = count_reg[sel_idx];
        sel_base  = ADDR_W'(ADDR_W'(sel_idx) * ADDR_W'(LIST_DEPTH));
        tail_sum  = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_count);
        if (tail_sum >= (CNT_W + 1)'(LIST_DEPTH))
        begin
            tail_wrap = tail_sum - (CNT_W + 1)'(LIST_DEPTH);
        end
        else
        begin
            tail_wrap = tail_sum;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        list_next       = list_reg;
        range_next      = range_reg;
        val_next        = val_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_live_next  = pend_live_reg;
        pend_list_next  = pend_list_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_val_next   = best_val_reg;
        res_next        = res_reg;
        rsp_item_next   = rsp_item_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        upd_en          = 1'b0;
        upd_idx         = sel_idx;
        upd_head        = sel_head;
        upd_count       = sel_count;
        mem_we          = 1'b0;
        mem_addr        = sel_base + ADDR_W'(sel_head);
        req_stall       = (state_reg != ST_IDLE);

        // Head comparison runs in the cycle after the memory read, on the registered read data.
        if (pend_valid_reg && pend_live_reg)
        begin
            if (!found_reg || (rdata_reg < best_val_reg))
            begin
                found_next    = 1'b1;
                best_next     = pend_list_reg;
                best_val_next = rdata_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    list_next  = LIST_W'(req_item.list_index);
                    range_next = (32'(req_item.list_index) < 32'(NUM_LISTS));
                    val_next   = req_item.value;
                    if (req_item.command == CMD_TAKE)
                    begin
                        scan_idx_next   = '0;
                        found_next      = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_APPEND:
            begin
                res_next.merged_value = '0;
                res_next.source_list  = '0;
                if (!range_reg || (sel_count == CNT_W'(LIST_DEPTH)))
                begin
                    res_next.status = STATUS_FULL;
                end
                else
                begin
                    res_next.status = STATUS_DONE;
                    mem_we          = 1'b1;
                    mem_addr        = sel_base + ADDR_W'(tail_wrap);
                    upd_en          = 1'b1;
                    upd_count       = sel_count + CNT_W'(1);
                end
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                pend_valid_next = 1'b1;
                pend_list_next  = scan_idx_reg;
                pend_live_next  = (sel_count != '0);
                if (scan_idx_reg == LIST_W'(NUM_LISTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + LIST_W'(1);
                end
            end
            ST_DRAIN:
            begin
                pend_valid_next = 1'b0;
                state_next      = ST_TAKE;
            end
            ST_TAKE:
            begin
                if (!found_reg)
                begin
                    res_next.status       = STATUS_EMPTY;
                    res_next.merged_value = '0;
                    res_next.source_list  = '0;
                end
                else
                begin
                    res_next.status       = STATUS_DONE;
                    res_next.merged_value = best_val_reg;
                    res_next.source_list  = 3'(best_reg);
                    upd_en                = 1'b1;
                    upd_count             = sel_count - CNT_W'(1);
                    if (sel_head == PTR_W'(LIST_DEPTH - 1))
                    begin
                        upd_head = '0;
                    end
                    else
                    begin
                        upd_head = sel_head + PTR_W'(1);
                    end
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_item_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

/* tb/tb_k_way_sorted_merge_unit.sv */
`default_nettype none

module tb_k_way_sorted_merge_unit;
    import kwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic      wait_drain;
        req_item_t item;
    } stim_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    k_way_sorted_merge_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    stim_t     pending_reqs[$];
    rsp_item_t merge_results_due[$];
    logic      drain_flag = 1'b0;
    int        fail_count = 0;

    logic signed [31:0] mirror_data [NUM_LISTS][LIST_DEPTH];
    int                 mirror_head [NUM_LISTS];
    int                 mirror_fill [NUM_LISTS];

    logic      offer;
    req_item_t next_item;
    int        burst_left = 0;
    int        gap_left = 0;

    int        hold_left = 0;
    logic      hold_done = 1'b0;
    int        rcv_count = 0;
    int        stall_mode = 0;
    int        mode_left = 0;
    int        stall_phase = 0;
    logic      stall_next;
    rsp_item_t want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic rsp_item_t merge_predict(req_item_t it);
        rsp_item_t          r;
        logic               found;
        int                 best;
        logic signed [31:0] best_val;
        int                 idx;
        r        = '0;
        found    = 1'b0;
        best     = 0;
        best_val = '0;
        idx      = int'(it.list_index);
        if (it.command == CMD_APPEND)
        begin
            if (idx >= NUM_LISTS || mirror_fill[idx] >= LIST_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                mirror_data[idx][(mirror_head[idx] + mirror_fill[idx]) % LIST_DEPTH] = it.value;
                mirror_fill[idx]++;
                r.status = STATUS_DONE;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                if (mirror_fill[i] > 0 && (!found || mirror_data[i][mirror_head[i]] < best_val))
                begin
                    found    = 1'b1;
                    best     = i;
                    best_val = mirror_data[i][mirror_head[i]];
                end
            end
            if (!found)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                mirror_head[best] = (mirror_head[best] + 1) % LIST_DEPTH;
                mirror_fill[best]--;
                r.status       = STATUS_DONE;
                r.merged_value = best_val;
                r.source_list  = best[2:0];
            end
        end
        return r;
    endfunction

    task automatic queue_request(logic cmd, logic [2:0] idx, logic signed [31:0] val);
        stim_t s;
        s.wait_drain      = drain_flag;
        s.item.command    = cmd;
        s.item.list_index = idx;
        s.item.value      = val;
        pending_reqs.push_back(s);
        drain_flag = 1'b0;
    endtask

    task automatic queue_drain(int n);
        for (int i = 0; i < n; i++)
            queue_request(CMD_TAKE, 3'($urandom_range(0, 7)), $urandom);
    endtask

    function automatic int step_up(int v, int step);
        longint nv;
        nv = longint'(v) + longint'(step);
        if (nv > 64'sd2147483647)
            nv = 64'sd2147483647;
        return int'(nv);
    endfunction

    initial
    begin : stimulus
        int   left [8];
        int   cur [8];
        logic started [8];
        int   remaining;
        int   live;
        int   kind;
        int   n;
        int   l;
        int   round;
        logic narrow;

        rst_n = 1'b0;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            mirror_head[i] = 0;
            mirror_fill[i] = 0;
        end

        queue_request(CMD_TAKE, 3'd7, 32'hFFFF_FFFF);
        queue_request(CMD_APPEND, 3'd0, 32'sh7FFF_FFFF);
        queue_request(CMD_APPEND, 3'd7, 32'sh8000_0000);
        queue_request(CMD_APPEND, 3'd3, 32'sd0);
        queue_request(CMD_APPEND, 3'd5, 32'sd0);
        queue_request(CMD_APPEND, 3'd3, -32'sd1);
        queue_drain(6);
        queue_request(CMD_APPEND, 3'd1, 32'sd5);
        queue_request(CMD_APPEND, 3'd2, 32'sd5);
        queue_request(CMD_APPEND, 3'd1, 32'sd6);
        queue_drain(4);

        round = 0;
        while (pending_reqs.size() < 1600)
        begin
            drain_flag = (round == 0) || ($urandom_range(0, 4) == 0);
            kind = (round == 0) ? 0 : $urandom_range(0, 19);
            live = 0;
            if (kind == 0)
            begin
                l = $urandom_range(0, 7);
                cur[0] = $urandom;
                n = LIST_DEPTH + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    queue_request(CMD_APPEND, 3'(l), cur[0]);
                    cur[0] = step_up(cur[0], $urandom_range(0, 1000));
                end
                live = LIST_DEPTH;
            end
            else if (kind <= 4)
            begin
                n = $urandom_range(5, 25);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        queue_request(CMD_APPEND, 3'($urandom_range(0, 7)), $urandom);
                        live++;
                    end
                    else
                    begin
                        queue_request(CMD_TAKE, 3'($urandom_range(0, 7)), $urandom);
                        if (live > 0)
                            live--;
                    end
                end
            end
            else
            begin
                narrow = ($urandom_range(0, 2) == 0);
                remaining = 0;
                for (int i = 0; i < 8; i++)
                begin
                    left[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    remaining += left[i];
                    started[i] = 1'b0;
                    cur[i] = narrow ? ($urandom_range(0, 8) - 4) : $signed($urandom);
                end
                while (remaining > 0)
                begin
                    do
                        l = $urandom_range(0, 7);
                    while (left[l] == 0);
                    if (started[l])
                        cur[l] = step_up(cur[l], narrow ? $urandom_range(0, 2)
                                                        : $urandom_range(0, 1 << $urandom_range(0, 28)));
                    started[l] = 1'b1;
                    queue_request(CMD_APPEND, 3'(l), cur[l]);
                    left[l]--;
                    remaining--;
                    live++;
                    if (live > 0 && $urandom_range(0, 4) == 0)
                    begin
                        queue_request(CMD_TAKE, 3'($urandom_range(0, 7)), $urandom);
                        live--;
                    end
                end
            end
            queue_drain(live + 1);
            round++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_reqs.size() > 0 || req_valid || merge_results_due.size() > 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("k_way_sorted_merge_unit test passed");
        else
            $display("k_way_sorted_merge_unit test failed");
        $finish;
    end

    initial
    begin
        #4_800_000;
        $display("k_way_sorted_merge_unit test failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item  <= '0;
        end
        else
        begin
            offer     = req_valid;
            next_item = req_item;
            if (req_valid && !req_stall)
            begin
                merge_results_due.push_back(merge_predict(req_item));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].wait_drain && merge_results_due.size() > 0))
                begin
                    next_item = pending_reqs.pop_front().item;
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            req_valid <= offer;
            req_item  <= next_item;
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up
    // and stalls its input while the sender keeps offering transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                rcv_count++;
            stall_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!hold_done && rcv_count >= 300)
            begin
                hold_done  = 1'b1;
                hold_left  = 500;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 300);
                end
                mode_left--;
                case (stall_mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 9) < 7);
                    default: stall_next = ((stall_phase % 5) < 2);
                endcase
            end
            rsp_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (merge_results_due.size() == 0)
            begin
                $display("%0t: unexpected transaction: status %0d value %0d list %0d",
                         $time, rsp_item.status, rsp_item.merged_value, rsp_item.source_list);
                fail_count++;
            end
            else
            begin
                want = merge_results_due.pop_front();
                if (rsp_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_item.status);
                    fail_count++;
                end
                if (rsp_item.merged_value !== want.merged_value)
                begin
                    $display("%0t: merged_value expected %0d actual %0d",
                             $time, want.merged_value, rsp_item.merged_value);
                    fail_count++;
                end
                if (rsp_item.source_list !== want.source_list)
                begin
                    $display("%0t: source_list expected %0d actual %0d",
                             $time, want.source_list, rsp_item.source_list);
                    fail_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire
